// ----- src/ckt_pkg.sv -----
// shared types and constants for the counting key table
package ckt_pkg;

	localparam int KeyWidth   = 32;
	localparam int CountWidth = 17;
	localparam int OpWidth    = 2;

	typedef logic [OpWidth-1:0]    op_t;
	typedef logic [KeyWidth-1:0]   key_t;
	typedef logic [CountWidth-1:0] count_t;

	localparam op_t OpAdd = 2'd0;
	localparam op_t OpDel = 2'd1;
	localparam op_t OpAsk = 2'd2;

	localparam count_t CountMax = {CountWidth{1'b1}};

	// a transaction as it walks down the row of cells
	typedef struct packed {
		logic   valid;
		op_t    op;
		key_t   key;
		logic   found;
		count_t occ;
		logic   ever;
	} qry_t;

endpackage

// ----- src/ckt_if.sv -----
// valid/ready channel interfaces for commands and responses
interface ckt_cmd_if;
	logic          valid;
	logic          ready;
	ckt_pkg::op_t  op;
	ckt_pkg::key_t key;

	modport source (output valid, output op, output key, input ready);
	modport sink (input valid, input op, input key, output ready);
endinterface

interface ckt_rsp_if;
	logic            valid;
	logic            ready;
	ckt_pkg::count_t occurrences;
	logic            ever_added;
	logic            table_full;

	modport source (output valid, output occurrences, output ever_added, output table_full,
		input ready);
	modport sink (input valid, input occurrences, input ever_added, input table_full,
		output ready);
endinterface

// ----- src/ckt_cell.sv -----
// one table entry: compares, claims or updates, then passes the transaction on
module ckt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  ckt_pkg::qry_t prev,
	output ckt_pkg::qry_t next
);
	import ckt_pkg::*;

	logic   used_q;
	key_t   key_q;
	count_t cnt_q;
	logic   hit;
	logic   claim;
	count_t inc;
	qry_t   nxt_d;
	logic   nxt_valid_q;
	qry_t   nxt_q;

	assign hit   = prev.valid && !prev.found && used_q && (key_q == prev.key);
	// used entries form a prefix, so the first free cell seen is the lowest one
	assign claim = prev.valid && !prev.found && !used_q && (prev.op == OpAdd);
	assign inc   = (cnt_q == CountMax) ? cnt_q : cnt_q + count_t'(1);

	always_comb begin
		nxt_d = prev;
		if (claim) begin
			nxt_d.found = 1'b1;
			nxt_d.occ   = count_t'(1);
		end else if (hit) begin
			nxt_d.found = 1'b1;
			case (prev.op)
				OpAdd: nxt_d.occ = inc;
				OpDel: nxt_d.occ = cnt_q;
				OpAsk: begin
					nxt_d.occ  = cnt_q;
					nxt_d.ever = 1'b1;
				end
				default: nxt_d.occ = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= 1'b0;
			nxt_valid_q <= 1'b0;
		end else if (adv) begin
			nxt_valid_q <= prev.valid;
			if (claim) begin
				used_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nxt_q <= nxt_d;
			if (claim) begin
				key_q <= prev.key;
				cnt_q <= count_t'(1);
			end else if (hit && prev.op == OpAdd) begin
				cnt_q <= inc;
			end else if (hit && prev.op == OpDel) begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		next       = nxt_q;
		next.valid = nxt_valid_q;
	end

endmodule

// ----- src/counting_key_table.sv -----
// counting key table: a multiset count per 32-bit key in a row of entry cells
//
// cmd channel takes op (add, del, ask) and key; rsp channel returns one
// transaction per command: occurrences, ever_added and table_full.
// each command walks the row of ENTRIES cells, one cell per cycle while the
// row advances; a cell holding the key updates or reports its count, and an
// add of a new key takes the first free cell it passes. an add that reaches
// the end unmatched flags full. each cell, then the output register, holds
// it; a new command is taken every cycle the row advances, so they overlap.
// reset empties the table at once; no clearing pass is needed.
// when the receiver stalls, the whole row and the output register hold,
// and cmd.ready drops until the waiting response is taken.
module counting_key_table #(
	parameter int ENTRIES = 256
) (
	input  logic clk,
	input  logic arst_n,
	ckt_cmd_if.sink   cmd,
	ckt_rsp_if.source rsp
);
	import ckt_pkg::*;

	qry_t   head;
	qry_t   chain [ENTRIES+1];
	logic   adv;
	logic   rsp_valid_q;
	count_t occ_q;
	logic   ever_q;
	logic   full_q;

	assign adv       = !rsp_valid_q || rsp.ready;
	assign cmd.ready = adv;

	always_comb begin
		head       = '0;
		head.valid = cmd.valid;
		head.op    = cmd.op;
		head.key   = cmd.key;
	end

	assign chain[0] = head;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ckt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.prev   (chain[i]),
			.next   (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= chain[ENTRIES].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			occ_q  <= chain[ENTRIES].occ;
			ever_q <= chain[ENTRIES].ever;
			full_q <= (chain[ENTRIES].op == OpAdd) && !chain[ENTRIES].found;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.occurrences = occ_q;
	assign rsp.ever_added  = ever_q;
	assign rsp.table_full  = full_q;

endmodule

// ----- dv/counting_key_table_tb.sv -----
// self-checking testbench for the counting key table: directed and random traffic
`timescale 1ns / 100ps

module counting_key_table_tb;
	import ckt_pkg::*;

	localparam int  Entries    = 256;
	localparam int  CycleLimit = 1_000_000;
	localparam int  HoldCycles = 600;
	localparam int  BurstLen   = 64;
	localparam op_t OpNone     = 2'd3;

	typedef struct packed {
		count_t occurrences;
		logic   ever_added;
		logic   table_full;
	} reply_t;

	// mirror of the table contents plus the queue of replies still owed
	class multiset_tracker;
		bit     used[Entries];
		key_t   keys[Entries];
		count_t counts[Entries];
		reply_t replies_due[$];
		int     errors, checked, n_full, n_ever;

		function int find_key(key_t k);
			for (int i = 0; i < Entries; i++)
				if (used[i] && keys[i] == k) return i;
			return -1;
		endfunction

		function int find_free();
			for (int i = 0; i < Entries; i++)
				if (!used[i]) return i;
			return -1;
		endfunction

		function void apply_cmd(op_t op, key_t k);
			reply_t r;
			int     idx, slot;
			r = '0;
			idx = find_key(k);
			case (op)
				OpAdd: begin
					if (idx >= 0) begin
						if (counts[idx] < CountMax) counts[idx]++;
						r.occurrences = counts[idx];
					end else begin
						slot = find_free();
						if (slot >= 0) begin
							used[slot]    = 1'b1;
							keys[slot]    = k;
							counts[slot]  = count_t'(1);
							r.occurrences = count_t'(1);
						end else begin
							r.table_full = 1'b1;
						end
					end
				end
				OpDel: begin
					if (idx >= 0) begin
						r.occurrences = counts[idx];
						counts[idx]   = '0;
					end
				end
				OpAsk: begin
					if (idx >= 0) begin
						r.ever_added  = 1'b1;
						r.occurrences = counts[idx];
					end
				end
				default: ;
			endcase
			replies_due.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 30) $display("[%0t] MISMATCH: %s", $time, msg);
		endtask

		task check_reply(count_t occ, logic ever, logic full);
			reply_t want;
			if (replies_due.size() == 0) begin
				report($sformatf("unexpected reply occ=%0d ever=%b full=%b", occ, ever, full));
				return;
			end
			want = replies_due.pop_front();
			checked++;
			if (occ !== want.occurrences)
				report($sformatf("occurrences %0d, expected %0d", occ, want.occurrences));
			if (ever !== want.ever_added)
				report($sformatf("ever_added %b, expected %b", ever, want.ever_added));
			if (full !== want.table_full)
				report($sformatf("table_full %b, expected %b", full, want.table_full));
			if (want.table_full) n_full++;
			if (want.ever_added) n_ever++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic tx_steady, rx_steady, rx_hold_req;
	int   cycles;
	key_t key_pool[$];
	multiset_tracker tracker;

	ckt_cmd_if cmd_ch();
	ckt_rsp_if rsp_ch();

	counting_key_table #(
		.ENTRIES(Entries)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch.sink),
		.rsp    (rsp_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CycleLimit) begin
				$display("timeout after %0d cycles", cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls, a steady stretch, and one long hold-off
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rx_hold_req && !hold_done) begin
				hold_left = HoldCycles;
				hold_done = 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= rx_steady || ($urandom_range(99) >= 22);
			end
		end
	end

	// accepted commands feed the tracker; accepted replies get checked
	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready)
			tracker.apply_cmd(cmd_ch.op, cmd_ch.key);
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			tracker.check_reply(rsp_ch.occurrences, rsp_ch.ever_added, rsp_ch.table_full);
	end

	task send_cmd(op_t op, key_t k);
		while (!tx_steady && $urandom_range(99) < 22) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.op    <= op;
		cmd_ch.key   <= k;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	task wait_drained();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.replies_due.size() != 0) @(posedge clk);
	endtask

	// mostly known keys with a share of fresh ones, all three ops and the unused code
	task send_random(int fresh_pct);
		int   r;
		key_t k;
		op_t  op;
		if ($urandom_range(99) < fresh_pct) k = $urandom;
		else k = key_pool[$urandom_range(key_pool.size() - 1)];
		r = $urandom_range(99);
		if (r < 45) op = OpAdd;
		else if (r < 70) op = OpAsk;
		else if (r < 96) op = OpDel;
		else op = OpNone;
		send_cmd(op, k);
	endtask

	initial begin
		key_t burst_key;
		tracker = new();
		burst_key = 32'h5A5A_0001;
		arst_n       = 1'b0;
		tx_steady    <= 1'b0;
		rx_steady    <= 1'b0;
		rx_hold_req  <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.op    <= OpAdd;
		cmd_ch.key   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extreme keys, repeat adds, delete and ask paths
		send_cmd(OpAsk, 32'h0000_0000);
		send_cmd(OpDel, 32'h1234_5678);
		send_cmd(OpAdd, 32'h0000_0000);
		send_cmd(OpAdd, 32'h0000_0000);
		send_cmd(OpAsk, 32'h0000_0000);
		send_cmd(OpAdd, 32'h7FFF_FFFF);
		send_cmd(OpAdd, 32'h8000_0000);
		send_cmd(OpAdd, 32'hFFFF_FFFF);
		send_cmd(OpAsk, 32'h8000_0000);
		send_cmd(OpDel, 32'h0000_0000);
		send_cmd(OpAsk, 32'h0000_0000);
		send_cmd(OpDel, 32'h0000_0000);
		send_cmd(OpAdd, 32'h0000_0000);
		send_cmd(OpNone, 32'h7FFF_FFFF);
		send_cmd(OpAsk, 32'h7FFF_FFFF);
		send_cmd(OpAdd, 32'h0000_0001);
		send_cmd(OpAsk, 32'hFFFF_FFFE);
		send_cmd(OpDel, 32'hFFFF_FFFF);
		send_cmd(OpAsk, 32'hFFFF_FFFF);
		wait_drained();

		// burst: back-to-back adds of one key, no stalls on either side
		tx_steady <= 1'b1;
		rx_steady <= 1'b1;
		for (int i = 0; i < BurstLen; i++) send_cmd(OpAdd, burst_key);
		send_cmd(OpAsk, burst_key);
		tx_steady <= 1'b0;
		rx_steady <= 1'b0;
		wait_drained();

		key_pool = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h0000_0001, burst_key};
		repeat (34) key_pool.push_back($urandom);

		// random traffic on a small key set; receiver holds off early so the row backs up
		rx_hold_req <= 1'b1;
		repeat (720) send_random(5);
		wait_drained();

		// fill the table with fresh keys until adds start coming back full
		for (int i = 0; i < 230; i++) begin
			key_t k;
			k = $urandom;
			if (i < 40) key_pool.push_back(k);
			send_cmd(OpAdd, k);
		end

		// random traffic on a full table
		repeat (560) send_random(15);
		wait_drained();
		repeat (Entries + 16) @(posedge clk);

		$display("checked %0d replies: %0d table-full adds, %0d asks of known keys",
			tracker.checked, tracker.n_full, tracker.n_ever);
		$display("covered empty, filling and full table, deletes and asks, receiver hold-off");
		if (tracker.errors == 0 && tracker.replies_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d replies missing", tracker.errors,
				tracker.replies_due.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/ckt_pkg.sv
src/ckt_if.sv
src/ckt_cell.sv
src/counting_key_table.sv
dv/counting_key_table_tb.sv
